FILE: rtl/core/olist_pkg.sv
// Shared constants, request and status codes, and the cell command type for the ordered list.
package olist_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int VALUE_W_DEF = 32;
  localparam int DEPTH_MAX   = 256;

  localparam int REQ_W     = 4;
  localparam int POS_W     = 4;
  localparam int IO_VAL_W  = 32;
  localparam int STAT_W    = 2;
  localparam int FOUND_W   = 5;
  localparam int CNT_OUT_W = 5;
  localparam int IDX_W     = $clog2(DEPTH_MAX);

  localparam logic [REQ_W-1:0] REQ_ADD        = 4'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT     = 4'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE_AT  = 4'd2;
  localparam logic [REQ_W-1:0] REQ_REM_FIRST  = 4'd3;
  localparam logic [REQ_W-1:0] REQ_REM_LAST   = 4'd4;
  localparam logic [REQ_W-1:0] REQ_FIND       = 4'd5;
  localparam logic [REQ_W-1:0] REQ_MOVE_INDEX = 4'd6;
  localparam logic [REQ_W-1:0] REQ_MOVE_VALUE = 4'd7;
  localparam logic [REQ_W-1:0] REQ_READ       = 4'd8;
  localparam logic [REQ_W-1:0] REQ_CLEAR      = 4'd9;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic             shift_en;
    logic             take_left;
    logic             load_en;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] load_idx;
  } cell_cmd_t;

endpackage

FILE: rtl/core/ordered_list_engine.sv
// Top level of the ordered list engine: a chain of entry cells under one request sequencer.
//
// Keeps an ordered list of up to DEPTH entries in a row of cells, one entry per cell. When an
// item is accepted, each cell compares its entry with the item value and registers a match bit;
// in the execute step that follows, the sequencer picks the first match, and the cell chain
// shifts, rotates or loads in one step while the result is registered. A new item is taken
// on the cycle after that. A result held by out_stall stretches the execute step until the
// output register is free. No clearing pass after reset; entries at or beyond the entry
// count are never read.
module ordered_list_engine
  import olist_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_W_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [REQ_W-1:0]          in_req_type,
  input  logic [IO_VAL_W-1:0]       in_item_value,
  input  logic [POS_W-1:0]          in_position,
  input  logic [POS_W-1:0]          in_target_position,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [STAT_W-1:0]         out_status,
  output logic signed [FOUND_W-1:0] out_found_position,
  output logic [IO_VAL_W-1:0]       out_read_value,
  output logic [CNT_OUT_W-1:0]      out_entry_count
);

  localparam int CW = $clog2(DEPTH+1);

  logic [VALUE_WIDTH-1:0]              key;
  logic                                cmp_en;
  logic [CW-1:0]                       count;
  cell_cmd_t                           cmd;
  logic [VALUE_WIDTH-1:0]              cmd_value;
  logic [DEPTH-1:0][VALUE_WIDTH-1:0]   cell_vals;
  logic [DEPTH-1:0]                    cell_match;

  assign key    = VALUE_WIDTH'(in_item_value);
  assign cmp_en = in_valid && !in_stall;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_val;
    logic [VALUE_WIDTH-1:0] right_val;

    if (g == 0) begin : g_first
      assign left_val = cell_vals[g];
    end else begin : g_mid_l
      assign left_val = cell_vals[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_val = cell_vals[g];
    end else begin : g_mid_r
      assign right_val = cell_vals[g+1];
    end

    olist_cell #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .IDX         (g)
    ) u_cell (
      .clk       (clk),
      .count     (count),
      .key       (key),
      .cmp_en    (cmp_en),
      .cmd       (cmd),
      .cmd_value (cmd_value),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (cell_vals[g]),
      .match     (cell_match[g])
    );
  end

  olist_ctrl #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_key             (key),
    .in_position        (in_position),
    .in_target_position (in_target_position),
    .cell_vals          (cell_vals),
    .cell_match         (cell_match),
    .count              (count),
    .cmd                (cmd),
    .cmd_value          (cmd_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_read_value     (out_read_value),
    .out_entry_count    (out_entry_count)
  );

endmodule

FILE: rtl/core/olist_cell.sv
// One list cell: holds an entry, compares it with the key, shifts to or from its neighbors.
module olist_cell
  import olist_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_W_DEF,
  parameter int IDX         = 0
) (
  input  logic                          clk,
  input  logic [$clog2(DEPTH+1)-1:0]    count,
  input  logic [VALUE_WIDTH-1:0]        key,
  input  logic                          cmp_en,
  input  cell_cmd_t                     cmd,
  input  logic [VALUE_WIDTH-1:0]        cmd_value,
  input  logic [VALUE_WIDTH-1:0]        left_val,
  input  logic [VALUE_WIDTH-1:0]        right_val,
  output logic [VALUE_WIDTH-1:0]        val,
  output logic                          match
);

  localparam int CW = $clog2(DEPTH+1);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
  localparam logic [CW-1:0]    MY_POS = CW'(IDX);

  logic [VALUE_WIDTH-1:0] val_r;
  logic [VALUE_WIDTH-1:0] val_nxt;
  logic                   match_r;

  always_comb begin
    val_nxt = val_r;
    if (cmd.load_en && (cmd.load_idx == MY_IDX)) begin
      val_nxt = cmd_value;
    end else if (cmd.shift_en && (MY_IDX >= cmd.lo) && (MY_IDX <= cmd.hi)) begin
      val_nxt = cmd.take_left ? left_val : right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (cmp_en) begin
      match_r <= (MY_POS < count) && (val_r == key);
    end
  end

  assign val   = val_r;
  assign match = match_r;

endmodule

FILE: rtl/core/olist_ctrl.sv
// Request sequencer: decodes an item, resolves the first match, drives the cell chain and result.
module olist_ctrl
  import olist_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_W_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [REQ_W-1:0]                    in_req_type,
  input  logic [VALUE_WIDTH-1:0]              in_key,
  input  logic [POS_W-1:0]                    in_position,
  input  logic [POS_W-1:0]                    in_target_position,
  input  logic [DEPTH-1:0][VALUE_WIDTH-1:0]   cell_vals,
  input  logic [DEPTH-1:0]                    cell_match,
  output logic [$clog2(DEPTH+1)-1:0]          count,
  output cell_cmd_t                           cmd,
  output logic [VALUE_WIDTH-1:0]              cmd_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [STAT_W-1:0]                   out_status,
  output logic signed [FOUND_W-1:0]           out_found_position,
  output logic [IO_VAL_W-1:0]                 out_read_value,
  output logic [CNT_OUT_W-1:0]                out_entry_count
);

  localparam int CW = $clog2(DEPTH+1);
  localparam int IW = $clog2(DEPTH);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           count_r;
  logic [CW-1:0]           cnt_nxt;
  logic [REQ_W-1:0]        req_r;
  logic [VALUE_WIDTH-1:0]  key_r;
  logic [POS_W-1:0]        pos_r;
  logic [POS_W-1:0]        tgt_r;

  logic                    out_valid_r;
  logic [STAT_W-1:0]       status_r;
  logic [FOUND_W-1:0]      found_r;
  logic [IO_VAL_W-1:0]     rd_r;
  logic [CNT_OUT_W-1:0]    cnt_out_r;

  logic                    accept;
  logic                    fire;
  logic                    fany;
  logic [IW-1:0]           fidx;
  logic [PW-1:0]           pos_w, tgt_w, cnt_w, src_w, to_w;
  logic [VALUE_WIDTH-1:0]  rd_val;
  logic                    mv_ok;
  logic [STAT_W-1:0]       status_c;
  logic [FOUND_W-1:0]      found_c;
  logic [IO_VAL_W-1:0]     rd_c;
  cell_cmd_t               cmd_c;
  logic [VALUE_WIDTH-1:0]  cmd_value_c;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign fire     = (state_r == S_EXEC) && (!out_valid_r || !out_stall);
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    fidx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (cell_match[i]) begin
        fidx = IW'(i);
      end
    end
  end
  assign fany = |cell_match;

  assign pos_w  = PW'(pos_r);
  assign tgt_w  = PW'(tgt_r);
  assign cnt_w  = PW'(count_r);
  assign src_w  = (req_r == REQ_MOVE_VALUE) ? PW'(fidx) : pos_w;
  assign to_w   = (src_w < tgt_w) ? (tgt_w - PW'(1)) : tgt_w;
  assign rd_val = cell_vals[IW'(src_w)];
  assign mv_ok  = (tgt_w < cnt_w) &&
                  ((req_r == REQ_MOVE_VALUE) ? fany : (pos_w < cnt_w));

  always_comb begin
    status_c    = ST_IGNORED;
    found_c     = '1;
    rd_c        = '0;
    cnt_nxt     = count_r;
    cmd_c       = '0;
    cmd_value_c = key_r;
    unique case (req_r)
      REQ_ADD: begin
        if (count_r == CW'(DEPTH)) begin
          status_c = ST_FULL;
        end else begin
          status_c       = ST_DONE;
          cmd_c.load_en  = 1'b1;
          cmd_c.load_idx = IDX_W'(count_r);
          cnt_nxt        = count_r + CW'(1);
        end
      end
      REQ_INSERT: begin
        if (pos_w > cnt_w) begin
          status_c = ST_IGNORED;
        end else if (count_r == CW'(DEPTH)) begin
          status_c = ST_FULL;
        end else begin
          status_c        = ST_DONE;
          cmd_c.load_en   = 1'b1;
          cmd_c.load_idx  = IDX_W'(pos_w);
          cmd_c.shift_en  = 1'b1;
          cmd_c.take_left = 1'b1;
          cmd_c.lo        = IDX_W'(pos_w);
          cmd_c.hi        = IDX_W'(DEPTH - 1);
          cnt_nxt         = count_r + CW'(1);
        end
      end
      REQ_REMOVE_AT, REQ_REM_FIRST: begin
        if ((req_r == REQ_REMOVE_AT) ? (pos_w < cnt_w) : (count_r != '0)) begin
          status_c       = ST_DONE;
          cmd_c.shift_en = 1'b1;
          cmd_c.lo       = (req_r == REQ_REMOVE_AT) ? IDX_W'(pos_w) : '0;
          cmd_c.hi       = IDX_W'(DEPTH - 1);
          cnt_nxt        = count_r - CW'(1);
        end
      end
      REQ_REM_LAST: begin
        if (count_r != '0) begin
          status_c = ST_DONE;
          cnt_nxt  = count_r - CW'(1);
        end
      end
      REQ_FIND: begin
        if (fany) begin
          status_c = ST_DONE;
          found_c  = FOUND_W'(fidx);
        end
      end
      REQ_MOVE_INDEX, REQ_MOVE_VALUE: begin
        if (mv_ok) begin
          status_c = ST_DONE;
          if (src_w != tgt_w) begin
            cmd_value_c    = rd_val;
            cmd_c.load_en  = 1'b1;
            cmd_c.load_idx = IDX_W'(to_w);
            cmd_c.shift_en = 1'b1;
            if (src_w < tgt_w) begin
              cmd_c.take_left = 1'b0;
              cmd_c.lo        = IDX_W'(src_w);
              cmd_c.hi        = IDX_W'(to_w);
            end else begin
              cmd_c.take_left = 1'b1;
              cmd_c.lo        = IDX_W'(to_w);
              cmd_c.hi        = IDX_W'(src_w);
            end
          end
        end
      end
      REQ_READ: begin
        if (pos_w < cnt_w) begin
          status_c = ST_DONE;
          rd_c     = IO_VAL_W'(rd_val);
        end
      end
      REQ_CLEAR: begin
        status_c = ST_DONE;
        cnt_nxt  = '0;
      end
      default: begin
        status_c = ST_IGNORED;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        count_r     <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req_type;
      key_r <= in_key;
      pos_r <= in_position;
      tgt_r <= in_target_position;
    end
    if (fire) begin
      status_r  <= status_c;
      found_r   <= found_c;
      rd_r      <= rd_c;
      cnt_out_r <= CNT_OUT_W'(cnt_nxt);
    end
  end

  assign count              = count_r;
  assign cmd                = fire ? cmd_c : '0;
  assign cmd_value          = cmd_value_c;
  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_found_position = found_r;
  assign out_read_value     = rd_r;
  assign out_entry_count    = cnt_out_r;

endmodule
